// ----- src/ycbcr_to_rgb_frame_writer_defines.svh -----
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_frame_writer_defines
// assertion macros shared by ycr_addr_gen and ycbcr_to_rgb_frame_writer
// ----------------------------------------------------------------------------
`ifndef YCBCR_TO_RGB_FRAME_WRITER_DEFINES_SVH
`define YCBCR_TO_RGB_FRAME_WRITER_DEFINES_SVH

// checked only out of reset
`define YCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define YCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ycr_pkg.sv -----
// ----------------------------------------------------------------------------
// ycr_pkg
// shared constants, types and helpers of the ycbcr to rgb frame writer
// ----------------------------------------------------------------------------
package ycr_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  localparam int DimW   = 13;
  localparam int CntW   = 12;
  localparam int AddrW  = 26;
  localparam int PitchW = 14;
  localparam int SumW   = 22;

  localparam logic [DimW-1:0] WidthReset  = 13'd640;
  localparam logic [DimW-1:0] HeightReset = 13'd480;

  localparam logic FmtRgb24  = 1'b0;
  localparam logic FmtRgb565 = 1'b1;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_OUT_FORMAT   = 2'd2
  } cfg_reg_t;

  localparam logic signed [SumW-1:0] CoefY  = 22'sd1192;
  localparam logic signed [SumW-1:0] CoefBu = 22'sd2066;
  localparam logic signed [SumW-1:0] CoefGu = 22'sd389;
  localparam logic signed [SumW-1:0] CoefGv = 22'sd833;
  localparam logic signed [SumW-1:0] CoefRv = 22'sd1187;

  localparam logic [15:0] Mask565R = 16'hF800;
  localparam logic [15:0] Mask565G = 16'h07E0;
  localparam logic [15:0] Mask565B = 16'h001F;
  localparam logic [PitchW-1:0] PitchRound = 14'h3;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             last;
  } ycr_pos_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [7:0] to_byte(input logic signed [SumW-1:0] s);
    logic [7:0] r;
    if (s <= 0) begin
      r = 8'd0;
    end else if (|s[SumW-2:18]) begin
      r = 8'd255;
    end else begin
      r = s[17:10];
    end
    return r;
  endfunction

endpackage

// ----- src/ycr_addr_gen.sv -----
// ----------------------------------------------------------------------------
// ycr_addr_gen
// raster position counters and bottom-up padded frame byte address
// ----------------------------------------------------------------------------
`include "ycbcr_to_rgb_frame_writer_defines.svh"

module ycr_addr_gen (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ycr_pkg::DimW-1:0]    frame_width,
  input  logic [ycr_pkg::DimW-1:0]    frame_height,
  input  logic                        out_format,
  output ycr_pkg::ycr_pos_t           pos
);

  logic [ycr_pkg::CntW-1:0]   col_r, col_nxt;
  logic [ycr_pkg::CntW-1:0]   row_r, row_nxt;
  logic [ycr_pkg::AddrW-1:0]  base_r, base_nxt;

  logic [ycr_pkg::DimW-1:0]   w_eff, h_eff, w_m1_full, h_m1_full;
  logic [ycr_pkg::CntW-1:0]   w_m1, h_m1;
  logic [ycr_pkg::PitchW-1:0] w_bytes, pitch_raw, pitch, col_off;
  logic [ycr_pkg::AddrW-1:0]  frame_base, base_cur;
  logic                       first_pix, line_end, frame_end;

  always_comb begin
    w_eff     = ycr_pkg::clamp_dim(frame_width, ycr_pkg::DimW'(ycr_pkg::MaxWidth));
    h_eff     = ycr_pkg::clamp_dim(frame_height, ycr_pkg::DimW'(ycr_pkg::MaxHeight));
    w_m1_full = w_eff - ycr_pkg::DimW'(1);
    h_m1_full = h_eff - ycr_pkg::DimW'(1);
    w_m1      = w_m1_full[ycr_pkg::CntW-1:0];
    h_m1      = h_m1_full[ycr_pkg::CntW-1:0];

    w_bytes = {w_eff, 1'b0} + ((out_format == ycr_pkg::FmtRgb565) ?
              ycr_pkg::PitchW'(0) : ycr_pkg::PitchW'(w_eff));
    pitch_raw = w_bytes + ycr_pkg::PitchRound;
    pitch     = pitch_raw & ~ycr_pkg::PitchRound;
    frame_base = ycr_pkg::AddrW'(h_m1) * ycr_pkg::AddrW'(pitch);

    first_pix = (col_r == '0) && (row_r == '0);
    base_cur  = first_pix ? frame_base : base_r;
    col_off   = ycr_pkg::PitchW'({col_r, 1'b0}) + ((out_format == ycr_pkg::FmtRgb565) ?
                ycr_pkg::PitchW'(0) : ycr_pkg::PitchW'(col_r));

    line_end  = (col_r >= w_m1);
    frame_end = (row_r >= h_m1);

    pos.addr = base_cur + ycr_pkg::AddrW'(col_off);
    pos.last = line_end && frame_end;

    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    if (accept) begin
      if (line_end) begin
        col_nxt  = '0;
        row_nxt  = frame_end ? '0 : row_r + ycr_pkg::CntW'(1);
        base_nxt = base_cur - ycr_pkg::AddrW'(pitch);
      end else begin
        col_nxt  = col_r + ycr_pkg::CntW'(1);
        base_nxt = base_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
    end
  end

  `YCR_ASSERT(a_last_wraps, accept && pos.last |=> (col_r == '0) && (row_r == '0), "last pixel did not restart the frame")
  `YCR_ASSERT(a_col_steps, accept && !line_end |=> col_r == $past(col_r) + ycr_pkg::CntW'(1), "column did not advance")
  `YCR_ASSERT(a_idle_holds, !accept |=> $stable(col_r) && $stable(row_r), "position moved without a transaction")

endmodule

// ----- src/ycr_color_conv.sv -----
// ----------------------------------------------------------------------------
// ycr_color_conv
// fixed-point color conversion and rgb24 / rgb565 packing
// ----------------------------------------------------------------------------
module ycr_color_conv (
  input  logic [7:0]  luma,
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  chroma_red,
  input  logic        out_format,
  output logic [23:0] pixel_value
);

  logic signed [ycr_pkg::SumW-1:0] y_s, u_s, v_s, ys;
  logic signed [ycr_pkg::SumW-1:0] sum_b, sum_g, sum_r;
  logic [7:0]                      b, g, r;
  logic [15:0]                     pix565;

  always_comb begin
    y_s = $signed({14'd0, luma}) - 22'sd16;
    u_s = $signed({14'd0, chroma_blue}) - 22'sd128;
    v_s = $signed({14'd0, chroma_red}) - 22'sd128;
    ys  = ycr_pkg::CoefY * y_s;

    sum_b = ys + ycr_pkg::CoefBu * u_s;
    sum_g = ys - ycr_pkg::CoefGu * u_s - ycr_pkg::CoefGv * v_s;
    sum_r = ys + ycr_pkg::CoefRv * v_s;

    b = ycr_pkg::to_byte(sum_b);
    g = ycr_pkg::to_byte(sum_g);
    r = ycr_pkg::to_byte(sum_r);

    pix565 = (16'(b >> 3) & ycr_pkg::Mask565B) |
             ((16'(g) << 3) & ycr_pkg::Mask565G) |
             ((16'(r) << 8) & ycr_pkg::Mask565R);

    if (out_format == ycr_pkg::FmtRgb565) begin
      pixel_value = {8'd0, pix565};
    end else begin
      pixel_value = {r, g, b};
    end
  end

endmodule

// ----- src/ycbcr_to_rgb_frame_writer.sv -----
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_frame_writer
// ycbcr pixel stream to rgb24 / rgb565 pixels with bottom-up frame addresses
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | luma, chroma_blue, chroma_red
//  out_    | output    | out_valid/out_stall| pixel_value, byte_address, last_pixel
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one transaction per clock sustained while out_stall stays low
//  stage 1 holds the pixel and its address, stage 2 the converted result
//  in_stall rises only when both stages are full and out_stall is high
//  reset clears valids, position counters and loads register defaults
//  cfg_ready is always high
// ----------------------------------------------------------------------------
`include "ycbcr_to_rgb_frame_writer_defines.svh"

module ycbcr_to_rgb_frame_writer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_luma,
  input  logic [7:0]               in_chroma_blue,
  input  logic [7:0]               in_chroma_red,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [23:0]              out_pixel_value,
  output logic [ycr_pkg::AddrW-1:0] out_byte_address,
  output logic                     out_last_pixel,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [ycr_pkg::DimW-1:0] cfg_data
);

  logic [ycr_pkg::DimW-1:0] width_r, height_r;
  logic                     format_r;

  logic                     s1_valid_r, s1_valid_nxt;
  logic [7:0]               s1_luma_r, s1_cb_r, s1_cr_r;
  logic                     s1_format_r;
  ycr_pkg::ycr_pos_t        s1_pos_r;

  logic                     out_valid_r, out_valid_nxt;
  logic [23:0]              out_pixel_r;
  logic [ycr_pkg::AddrW-1:0] out_addr_r;
  logic                     out_last_r;

  logic                     in_accept, out_free, s1_move;
  ycr_pkg::ycr_pos_t        pos;
  logic [23:0]              pixel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ycr_pkg::WidthReset;
      height_r <= ycr_pkg::HeightReset;
      format_r <= ycr_pkg::FmtRgb24;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ycr_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_data;
        ycr_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_data;
        ycr_pkg::CFG_OUT_FORMAT:   format_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    s1_move       = s1_valid_r && out_free;
    in_stall      = s1_valid_r && !out_free;
    in_accept     = in_valid && !in_stall;
    s1_valid_nxt  = in_accept || (s1_valid_r && !out_free);
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  ycr_addr_gen u_addr_gen (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .frame_width  (width_r),
    .frame_height (height_r),
    .out_format   (format_r),
    .pos          (pos)
  );

  ycr_color_conv u_color_conv (
    .luma        (s1_luma_r),
    .chroma_blue (s1_cb_r),
    .chroma_red  (s1_cr_r),
    .out_format  (s1_format_r),
    .pixel_value (pixel)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_luma_r   <= in_luma;
      s1_cb_r     <= in_chroma_blue;
      s1_cr_r     <= in_chroma_red;
      s1_format_r <= format_r;
      s1_pos_r    <= pos;
    end
    if (s1_move) begin
      out_pixel_r <= pixel;
      out_addr_r  <= s1_pos_r.addr;
      out_last_r  <= s1_pos_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_pixel_r;
  assign out_byte_address = out_addr_r;
  assign out_last_pixel   = out_last_r;

  `YCR_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !s1_valid_r && !out_valid_r, "valids not cleared by reset")
  `YCR_ASSERT(a_stall_needs_full, in_stall |-> s1_valid_r && out_valid_r, "input stalled with room in the pipeline")
  `YCR_ASSERT(a_s1_moves_out, s1_move |=> out_valid_r, "stage 1 transaction lost on its way out")
  `YCR_ASSERT(a_no_invented, !s1_valid_r && out_free |=> !out_valid_r, "result appeared without a transaction")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks ycbcr_to_rgb_frame_writer against a cycle-free predictor of its
// color conversion and bottom-up frame addressing, over directed corner
// pixels, clamped and mid-frame geometry changes and random frames,
// with random idling on the input and random stall on the result side
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned AddrMask   = (1 << ycr_pkg::AddrW) - 1;
  localparam int          IdlePct    = 33;
  localparam int          RandomPix  = 1650;

  typedef struct {
    logic [23:0]               value;
    logic [ycr_pkg::AddrW-1:0] addr;
    logic                      last;
  } pixel_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                in_luma;
  logic [7:0]                in_chroma_blue;
  logic [7:0]                in_chroma_red;
  logic                      out_valid;
  logic                      out_stall;
  logic [23:0]               out_pixel_value;
  logic [ycr_pkg::AddrW-1:0] out_byte_address;
  logic                      out_last_pixel;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [1:0]                cfg_index;
  logic [ycr_pkg::DimW-1:0]  cfg_data;

  // register and position copies
  logic [ycr_pkg::DimW-1:0]  reg_width;
  logic [ycr_pkg::DimW-1:0]  reg_height;
  logic              reg_format;
  int unsigned       col_pos;
  int unsigned       row_pos;
  int unsigned       line_base;

  pixel_t            expected_pixels[$];
  pixel_t            want;
  bit                steady_flow;
  int                error_count;
  int                pixels_checked;
  int                frames_seen;
  int                cfg_writes;

  ycbcr_to_rgb_frame_writer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_luma          (in_luma),
    .in_chroma_blue   (in_chroma_blue),
    .in_chroma_red    (in_chroma_red),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_value  (out_pixel_value),
    .out_byte_address (out_byte_address),
    .out_last_pixel   (out_last_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= steady_flow ? 1'b0 : ($urandom_range(0, 99) < IdlePct);
  end

  function automatic logic [7:0] sat_channel(input int sum);
    if (sum <= 0) begin
      return 8'd0;
    end
    if (sum / 1024 > 255) begin
      return 8'd255;
    end
    return 8'(sum / 1024);
  endfunction

  function automatic int unsigned fit_dim(input logic [ycr_pkg::DimW-1:0] v,
                                          input int unsigned lim);
    if (v == '0) begin
      return 1;
    end
    if (v > lim) begin
      return lim;
    end
    return 32'(v);
  endfunction

  function automatic void predict_pixel(input logic [7:0] y, input logic [7:0] cb,
                                        input logic [7:0] cr);
    int          luma_term;
    int          cb_off;
    int          cr_off;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    int unsigned w;
    int unsigned h;
    int unsigned bpp;
    int unsigned pitch;
    pixel_t      p;
    luma_term = 1192 * (int'(y) - 16);
    cb_off    = int'(cb) - 128;
    cr_off    = int'(cr) - 128;
    blue      = sat_channel(luma_term + 2066 * cb_off);
    green     = sat_channel(luma_term - 389 * cb_off - 833 * cr_off);
    red       = sat_channel(luma_term + 1187 * cr_off);
    w         = fit_dim(reg_width, ycr_pkg::MaxWidth);
    h         = fit_dim(reg_height, ycr_pkg::MaxHeight);
    bpp       = (reg_format == ycr_pkg::FmtRgb565) ? 2 : 3;
    pitch     = (w * bpp + 3) & ~32'd3;
    if (reg_format == ycr_pkg::FmtRgb565) begin
      p.value = {8'h00, red[7:3], green[7:2], blue[7:3]};
    end else begin
      p.value = {red, green, blue};
    end
    if (col_pos == 0 && row_pos == 0) begin
      line_base = ((h - 1) * pitch) & AddrMask;
    end
    p.addr = ycr_pkg::AddrW'((line_base + col_pos * bpp) & AddrMask);
    p.last = 1'b0;
    if (col_pos >= w - 1) begin
      col_pos = 0;
      if (row_pos >= h - 1) begin
        row_pos = 0;
        p.last  = 1'b1;
      end else begin
        row_pos++;
      end
      line_base = (line_base - pitch) & AddrMask;
    end else begin
      col_pos++;
    end
    expected_pixels.push_back(p);
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned got_val);
    if (exp_val != got_val) begin
      error_count++;
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        $error("result transaction with nothing expected: value %h address %h",
               out_pixel_value, out_byte_address);
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_value", 32'(want.value), 32'(out_pixel_value));
        check_field("byte_address", 32'(want.addr), 32'(out_byte_address));
        check_field("last_pixel", 32'(want.last), 32'(out_last_pixel));
        pixels_checked++;
        if (out_last_pixel) begin
          frames_seen++;
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic push_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr);
    while (!steady_flow && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_luma        <= y;
    in_chroma_blue <= cb;
    in_chroma_red  <= cr;
    do @(posedge clk); while (in_stall);
    predict_pixel(y, cb, cr);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(input ycr_pkg::cfg_reg_t idx, input logic [ycr_pkg::DimW-1:0] val);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ycr_pkg::CFG_FRAME_WIDTH: begin
        reg_width = val;
      end
      ycr_pkg::CFG_FRAME_HEIGHT: begin
        reg_height = val;
      end
      ycr_pkg::CFG_OUT_FORMAT: begin
        reg_format = val[0];
      end
      default: begin
      end
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a 1x1 frame closes any open frame so the next pixel starts a new one
  task automatic close_frame();
    set_reg(ycr_pkg::CFG_FRAME_WIDTH, 13'd1);
    set_reg(ycr_pkg::CFG_FRAME_HEIGHT, 13'd1);
    push_pixel(8'd90, 8'd60, 8'd200);
  endtask

  task automatic test_reset_defaults();
    push_pixel(8'd16, 8'd128, 8'd128);
    push_pixel(8'd235, 8'd128, 8'd128);
    push_pixel(8'd81, 8'd90, 8'd240);
  endtask

  task automatic test_color_extremes();
    int k;
    for (k = 0; k < 8; k++) begin
      push_pixel(k[0] ? 8'd255 : 8'd0, k[1] ? 8'd255 : 8'd0, k[2] ? 8'd255 : 8'd0);
    end
    // zero sum, smallest positive sum
    push_pixel(8'd16, 8'd128, 8'd128);
    push_pixel(8'd17, 8'd128, 8'd128);
    set_reg(ycr_pkg::CFG_OUT_FORMAT, ycr_pkg::DimW'(ycr_pkg::FmtRgb565));
    push_pixel(8'd255, 8'd255, 8'd0);
    push_pixel(8'd128, 8'd0, 8'd255);
    push_pixel(8'd200, 8'd200, 8'd60);
  endtask

  task automatic test_dimension_limits();
    close_frame();
    // zero size acts as one
    set_reg(ycr_pkg::CFG_FRAME_WIDTH, 13'd0);
    set_reg(ycr_pkg::CFG_FRAME_HEIGHT, 13'd0);
    push_pixel(8'd100, 8'd100, 8'd100);
    // oversize clamps to the maximum
    set_reg(ycr_pkg::CFG_FRAME_WIDTH, 13'h1FFF);
    set_reg(ycr_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
    push_pixel(8'd50, 8'd180, 8'd30);
    push_pixel(8'd150, 8'd20, 8'd220);
    set_reg(ycr_pkg::CFG_OUT_FORMAT, ycr_pkg::DimW'(ycr_pkg::FmtRgb24));
    push_pixel(8'd240, 8'd128, 8'd128);
  endtask

  task automatic test_midframe_geometry();
    close_frame();
    set_reg(ycr_pkg::CFG_FRAME_WIDTH, 13'd2);
    set_reg(ycr_pkg::CFG_FRAME_HEIGHT, 13'd2);
    push_pixel(8'd30, 8'd140, 8'd110);
    push_pixel(8'd60, 8'd120, 8'd150);
    // taller frame after the base already reached zero, address wraps
    set_reg(ycr_pkg::CFG_FRAME_HEIGHT, 13'd4);
    push_pixel(8'd90, 8'd100, 8'd170);
    push_pixel(8'd120, 8'd80, 8'd190);
    push_pixel(8'd150, 8'd60, 8'd210);
  endtask

  function automatic logic [ycr_pkg::DimW-1:0] pick_dim(input int small_max);
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'h1FFF;
      2: return 13'(ycr_pkg::MaxWidth);
      3: return 13'($urandom & 32'h1FFF);
      default: return 13'($urandom_range(1, small_max));
    endcase
  endfunction

  task automatic test_random_frames();
    int         sent;
    int         phase;
    int         n;
    int         k;
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
    sent  = 0;
    phase = 0;
    while (sent < RandomPix) begin
      set_reg(ycr_pkg::CFG_FRAME_WIDTH, pick_dim(12));
      set_reg(ycr_pkg::CFG_FRAME_HEIGHT, pick_dim(6));
      set_reg(ycr_pkg::CFG_OUT_FORMAT, ycr_pkg::DimW'($urandom_range(0, 1)));
      steady_flow = (phase == 4);
      n = steady_flow ? 240 : $urandom_range(30, 140);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          y  = 8'($urandom_range(12, 22));
          cb = 8'($urandom_range(118, 138));
          cr = 8'($urandom_range(118, 138));
        end else begin
          y  = 8'($urandom);
          cb = 8'($urandom);
          cr = 8'($urandom);
        end
        push_pixel(y, cb, cr);
      end
      wait_drain();
      steady_flow = 1'b0;
      sent += n;
      phase++;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_luma        = '0;
    in_chroma_blue = '0;
    in_chroma_red  = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = ycr_pkg::CFG_FRAME_WIDTH;
    cfg_data       = '0;
    steady_flow    = 1'b0;
    error_count    = 0;
    pixels_checked = 0;
    frames_seen    = 0;
    cfg_writes     = 0;
    reg_width      = ycr_pkg::WidthReset;
    reg_height     = ycr_pkg::HeightReset;
    reg_format     = ycr_pkg::FmtRgb24;
    col_pos        = 0;
    row_pos        = 0;
    line_base      = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_color_extremes();
    test_dimension_limits();
    test_midframe_geometry();
    test_random_frames();
    wait_drain();

    $display("tb_top: %0d pixels compared, %0d frame ends, %0d register writes",
             pixels_checked, frames_seen, cfg_writes);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
